// ===== design/mlt_pkg.sv =====
// shared types and constants of the mac learning table with aging
package mlt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int MAC_W   = 48;
    localparam int PORT_W  = 4;
    localparam int AGE_W   = 8;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [AGE_W-1:0] INIT_AGE_RESET = AGE_W'(30);

    // opcodes of a request transaction
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_REFRESHED = 2'd0;
    localparam logic [1:0] ST_LEARNED   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_AGED      = 2'd3;

    // configuration register indexes
    localparam logic [0:0] REG_INITIAL_AGE = 1'b0;

    typedef struct packed {
        logic              opcode;
        logic [MAC_W-1:0]  source_mac;
        logic [PORT_W-1:0] port;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] out_port;
        logic              last;
    } rsp_t;

    // one table slot as it travels round the ring
    typedef struct packed {
        logic              valid;
        logic              expired;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [AGE_W-1:0]  age;
    } entry_t;

    // controls broadcast to every cell
    typedef struct packed {
        logic cmp;
        logic dec;
        logic apply;
        logic rotate;
    } cell_ctrl_t;

endpackage

// ===== design/mlt_cell.sv =====
// one table slot: compare, refresh, learn, age and ring shift
module mlt_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mlt_pkg::cell_ctrl_t         ctrl,
    input  logic                        learn_sel,
    input  mlt_pkg::entry_t             nbr,
    input  logic [mlt_pkg::MAC_W-1:0]   frame_mac,
    input  logic [mlt_pkg::PORT_W-1:0]  frame_port,
    input  logic [mlt_pkg::AGE_W-1:0]   init_age,
    output mlt_pkg::entry_t             entry,
    output logic                        hit
);
    import mlt_pkg::*;

    entry_t            entry_cur, entry_next;
    logic              valid_reg, expired_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [PORT_W-1:0] port_reg;
    logic [AGE_W-1:0]  age_reg;
    logic              hit_reg, hit_next;

    assign entry_cur = '{valid: valid_reg, expired: expired_reg, mac: mac_reg,
                         port: port_reg, age: age_reg};

    always_comb
    begin
        entry_next = entry_cur;
        hit_next   = hit_reg;
        if (ctrl.rotate)
        begin
            entry_next = nbr;
        end
        else if (ctrl.dec)
        begin
            if (entry_cur.valid)
            begin
                if (entry_cur.age <= AGE_W'(1))
                begin
                    entry_next.age     = '0;
                    entry_next.valid   = 1'b0;
                    entry_next.expired = 1'b1;
                end
                else
                begin
                    entry_next.age = entry_cur.age - AGE_W'(1);
                end
            end
        end
        else if (ctrl.cmp)
        begin
            hit_next = entry_cur.valid && (entry_cur.mac == frame_mac);
        end
        else if (ctrl.apply)
        begin
            if (hit_reg)
            begin
                entry_next.age = init_age;
            end
            else if (learn_sel)
            begin
                entry_next.valid = 1'b1;
                entry_next.mac   = frame_mac;
                entry_next.port  = frame_port;
                entry_next.age   = init_age;
            end
        end
    end

    // valid and expiry marks are control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            expired_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            valid_reg   <= entry_next.valid;
            expired_reg <= entry_next.expired;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg  <= entry_next.mac;
        port_reg <= entry_next.port;
        age_reg  <= entry_next.age;
    end

    assign entry = entry_cur;
    assign hit   = hit_reg;

endmodule

// ===== design/mac_learning_table_aging.sv =====
// top level of the mac learning table with aging: cell ring, sequencer, apb port
// frame: accepted, compared in every cell, then applied; result registered with the apply, which waits for the output
// tick: parallel aging in every cell, then ENTRIES ring shifts, held while an expired slot waits for the output
// one request at a time: req_stall holds new requests until the sequencer is back in idle
// the ring shift through cell 0 sets the tick length; results leave one per cycle while rsp_stall is low
// reset clears all valid bits and sets initial_age to 30; slot payloads are not reset
module mac_learning_table_aging (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         req_valid,
    output logic                         req_stall,
    input  mlt_pkg::req_t                req,
    // result channel
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output mlt_pkg::rsp_t                rsp,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mlt_pkg::APB_AW-1:0]   paddr,
    input  logic [mlt_pkg::APB_DW-1:0]   pwdata,
    output logic [mlt_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import mlt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CMP   = 5'b00010,
        S_FRAME = 5'b00100,
        S_DEC   = 5'b01000,
        S_SCAN  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [AGE_W-1:0]    init_age_reg, init_age_next;
    logic [MAC_W-1:0]    frame_mac_reg, frame_mac_next;
    logic [PORT_W-1:0]   frame_port_reg, frame_port_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    cell_ctrl_t          ctrl;
    entry_t              cell_entry [ENTRIES];
    entry_t              wrap_entry;
    logic [ENTRIES-1:0]  cell_hit;
    logic [ENTRIES-1:0]  free_vec;
    logic [ENTRIES-1:0]  learn_vec;
    logic                any_hit;
    logic                any_free;
    logic [PORT_W-1:0]   hit_port;
    logic                rest_expired;
    logic                can_emit;
    logic                req_accept;
    logic                cfg_write;

    // ---------------------------------------------------------------
    // configuration port, always ready
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        init_age_next = init_age_reg;
        if (cfg_write && (paddr[2:2] == REG_INITIAL_AGE))
        begin
            init_age_next = pwdata[AGE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2:2] == REG_INITIAL_AGE)
        begin
            prdata = {{(APB_DW-AGE_W){1'b0}}, init_age_reg};
        end
    end

    // ---------------------------------------------------------------
    // ring of cells: cell i takes from cell i+1, the last from cell 0;
    // cell 0 is the report point, its expiry mark is dropped on the wrap
    // ---------------------------------------------------------------
    always_comb
    begin
        wrap_entry         = cell_entry[0];
        wrap_entry.expired = 1'b0;
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        entry_t nbr;
        if (i == ENTRIES - 1)
        begin : g_wrap
            assign nbr = wrap_entry;
        end
        else
        begin : g_link
            assign nbr = cell_entry[i+1];
        end

        mlt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .learn_sel  (learn_vec[i]),
            .nbr        (nbr),
            .frame_mac  (frame_mac_reg),
            .frame_port (frame_port_reg),
            .init_age   (init_age_reg),
            .entry      (cell_entry[i]),
            .hit        (cell_hit[i])
        );

        assign free_vec[i] = ~cell_entry[i].valid;
    end

    // lowest free slot: isolate the lowest set bit with one wide add
    assign any_hit   = |cell_hit;
    assign any_free  = |free_vec;
    assign learn_vec = any_hit ? '0 : (free_vec & (~free_vec + ENTRIES'(1)));

    // stored port of the hit slot, at most one hit since macs are unique
    always_comb
    begin
        hit_port = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_port = hit_port | (cell_hit[i] ? cell_entry[i].port : '0);
        end
    end

    // any expiry still waiting behind the report point
    always_comb
    begin
        rest_expired = 1'b0;
        for (int i = 1; i < ENTRIES; i++)
        begin
            rest_expired = rest_expired | cell_entry[i].expired;
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign can_emit   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        frame_mac_next  = frame_mac_reg;
        frame_port_next = frame_port_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        ctrl            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    frame_mac_next  = req.source_mac;
                    frame_port_next = req.port;
                    state_next      = (req.opcode == OP_TICK) ? S_DEC : S_CMP;
                end
            end
            S_CMP:
            begin
                ctrl.cmp   = 1'b1;
                state_next = S_FRAME;
            end
            S_FRAME:
            begin
                if (can_emit)
                begin
                    ctrl.apply       = 1'b1;
                    rsp_valid_next   = 1'b1;
                    rsp_next.mac     = frame_mac_reg;
                    rsp_next.last    = 1'b1;
                    priority if (any_hit)
                    begin
                        rsp_next.status   = ST_REFRESHED;
                        rsp_next.out_port = hit_port;
                    end
                    else if (any_free)
                    begin
                        rsp_next.status   = ST_LEARNED;
                        rsp_next.out_port = frame_port_reg;
                    end
                    else
                    begin
                        rsp_next.status   = ST_FULL;
                        rsp_next.out_port = frame_port_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DEC:
            begin
                ctrl.dec   = 1'b1;
                cnt_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // hold the ring while an expired slot waits for the output
                if (!cell_entry[0].expired || can_emit)
                begin
                    ctrl.rotate = 1'b1;
                    if (cell_entry[0].expired)
                    begin
                        rsp_valid_next    = 1'b1;
                        rsp_next.status   = ST_AGED;
                        rsp_next.mac      = cell_entry[0].mac;
                        rsp_next.out_port = cell_entry[0].port;
                        rsp_next.last     = ~rest_expired;
                    end
                    if (cnt_reg == IDX_W'(ENTRIES - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            init_age_reg  <= INIT_AGE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            init_age_reg  <= init_age_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // transaction payloads
    always_ff @(posedge clk)
    begin
        frame_mac_reg  <= frame_mac_next;
        frame_port_reg <= frame_port_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
